>>> sv/aes_cbc_cipher_macros.svh
// Assertion macros used by the port checker.
`ifndef AES_CBC_CIPHER_MACROS_SVH
`define AES_CBC_CIPHER_MACROS_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define ACC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ACC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/aes_cbc_pkg.sv
// Types, constants and AES round functions shared by the cipher modules.
package aes_cbc_pkg;

    localparam int STREAMS_DEF = 4;
    localparam int BLOCK_BYTES = 16;

    typedef enum logic [2:0] {
        CFG_KEY_WORD_0   = 3'd0,
        CFG_KEY_WORD_1   = 3'd1,
        CFG_KEY_WORD_2   = 3'd2,
        CFG_KEY_WORD_3   = 3'd3,
        CFG_KEY_SIZE     = 3'd4,
        CFG_DECRYPT_MODE = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_LOAD  = 2'd1,
        OP_ROUND = 2'd2,
        OP_LAST  = 2'd3
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic       dec;
        logic [3:0] rk_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic       busy;
        logic [3:0] nr;
    } key_stat_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
        8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
        8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
        8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
        8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
        8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
        8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
        8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
        8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
        8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
        8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
        8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
        8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
        8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
        8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
        8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
        8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
        8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
        8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
        8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
        8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
        8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
        8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
        8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
        8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
        8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
        8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
        8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
        8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
        8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
        8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
        8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
    };

    // rounds from the key size code; the spare code behaves as AES-256
    function automatic logic [3:0] nr_of(input logic [1:0] ks);
        logic [3:0] nr;
        unique case (ks)
            2'd0:    nr = 4'd10;
            2'd1:    nr = 4'd12;
            default: nr = 4'd14;
        endcase
        return nr;
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // byte 0 of the state sits in bits 127..120
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        int src;
        int dst;
        t = '0;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                dst = r + 4 * c;
                src = r + 4 * ((c + r) & 3);
                t[127 - 8 * dst -: 8] = SBOX[s[127 - 8 * src -: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
        logic [127:0] t;
        int src;
        int dst;
        t = '0;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                src = r + 4 * c;
                dst = r + 4 * ((c + r) & 3);
                t[127 - 8 * dst -: 8] = INV_SBOX[s[127 - 8 * src -: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_cols(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 32 * c -: 8];
            a1 = s[119 - 32 * c -: 8];
            a2 = s[111 - 32 * c -: 8];
            a3 = s[103 - 32 * c -: 8];
            t[127 - 32 * c -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
            t[119 - 32 * c -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
            t[111 - 32 * c -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
            t[103 - 32 * c -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
        end
        return t;
    endfunction

    // products by 9, 11, 13 and 14 from doublings
    function automatic logic [127:0] inv_mix_cols(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0] a [4];
        logic [7:0] m9 [4];
        logic [7:0] m11 [4];
        logic [7:0] m13 [4];
        logic [7:0] m14 [4];
        logic [7:0] x2, x4, x8;
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                a[k]   = s[127 - 32 * c - 8 * k -: 8];
                x2     = xt(a[k]);
                x4     = xt(x2);
                x8     = xt(x4);
                m9[k]  = x8 ^ a[k];
                m11[k] = x8 ^ x2 ^ a[k];
                m13[k] = x8 ^ x4 ^ a[k];
                m14[k] = x8 ^ x4 ^ x2;
            end
            t[127 - 32 * c -: 8] = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
            t[119 - 32 * c -: 8] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
            t[111 - 32 * c -: 8] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
            t[103 - 32 * c -: 8] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
        end
        return t;
    endfunction

endpackage

>>> sv/aes_cbc_kexp.sv
// Key registers and the word-per-cycle key schedule builder with its round-key store.
module aes_cbc_kexp
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [63:0]            cfg_data,
    input  logic [3:0]             rk_idx,
    output logic [127:0]           rk,
    output aes_cbc_pkg::key_stat_t stat
);

    logic [63:0]  key_reg [4];
    logic [1:0]   ksize_reg;
    logic         busy_reg;
    logic [5:0]   cnt_reg;
    logic [2:0]   j_reg;
    logic [7:0]   rcon_reg;
    logic [31:0]  win_reg [8];
    logic [127:0] rk_reg [16];

    logic [3:0]  nr;
    logic [3:0]  nk;
    logic [5:0]  total;
    logic        restart;
    logic [31:0] t;
    logic [31:0] far;
    logic [31:0] w_new;
    logic [63:0] kw;

    assign nr    = aes_cbc_pkg::nr_of(ksize_reg);
    assign nk    = nr - 4'd6;
    assign total = {nr, 2'b00} + 6'd4;

    always_comb
    begin
        restart = 1'b0;
        if (cfg_we)
        begin
            unique case (aes_cbc_pkg::cfg_idx_t'(cfg_index))
                aes_cbc_pkg::CFG_KEY_WORD_0,
                aes_cbc_pkg::CFG_KEY_WORD_1,
                aes_cbc_pkg::CFG_KEY_WORD_2,
                aes_cbc_pkg::CFG_KEY_WORD_3,
                aes_cbc_pkg::CFG_KEY_SIZE: restart = 1'b1;
                default:                   restart = 1'b0;
            endcase
        end
    end

    // w[i - nk] sits nk - 1 places down the window
    always_comb
    begin
        unique case (nk)
            4'd4:    far = win_reg[3];
            4'd6:    far = win_reg[5];
            default: far = win_reg[7];
        endcase
    end

    always_comb
    begin
        kw = key_reg[cnt_reg[2:1]];
        t  = win_reg[0];
        if (j_reg == 3'd0)
            t = aes_cbc_pkg::sub_word({t[23:0], t[31:24]}) ^ {rcon_reg, 24'h0};
        else if (nk == 4'd8 && j_reg == 3'd4)
            t = aes_cbc_pkg::sub_word(t);
        if (cnt_reg < {2'b00, nk})
            w_new = cnt_reg[0] ? kw[31:0] : kw[63:32];
        else
            w_new = far ^ t;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '{default: '0};
            ksize_reg <= '0;
            busy_reg  <= 1'b1;
            cnt_reg   <= '0;
            j_reg     <= '0;
            rcon_reg  <= 8'h01;
        end
        else if (restart)
        begin
            if (aes_cbc_pkg::cfg_idx_t'(cfg_index) == aes_cbc_pkg::CFG_KEY_SIZE)
                ksize_reg <= cfg_data[1:0];
            else
                key_reg[cfg_index[1:0]] <= cfg_data;
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            j_reg    <= '0;
            rcon_reg <= 8'h01;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            j_reg   <= ({1'b0, j_reg} == nk - 4'd1) ? 3'd0 : j_reg + 3'd1;
            if (cnt_reg >= {2'b00, nk} && j_reg == 3'd0)
                rcon_reg <= aes_cbc_pkg::xt(rcon_reg);
            if (cnt_reg == total - 6'd1)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !restart)
        begin
            win_reg[0] <= w_new;
            for (int k = 1; k < 8; k++)
                win_reg[k] <= win_reg[k - 1];
            rk_reg[cnt_reg[5:2]][(2'd3 - cnt_reg[1:0]) * 32 +: 32] <= w_new;
        end
    end

    assign rk        = rk_reg[rk_idx];
    assign stat.busy = busy_reg;
    assign stat.nr   = nr;

endmodule

>>> sv/aes_cbc_ctrl.sv
// Controller: accepts words, sequences the rounds, owns the output valid flag.
module aes_cbc_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [63:0]            cfg_data,
    input  aes_cbc_pkg::key_stat_t kstat,
    output aes_cbc_pkg::dp_cmd_t   cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic [3:0]  step_reg, step_next;
    logic [3:0]  nr_reg, nr_next;
    logic        dec_reg, dec_next;
    logic        mode_reg;
    logic        out_valid_reg;
    logic        accept;
    logic        last_go;

    assign s_tready = (state_reg == ST_IDLE) && !kstat.busy && !cfg_we;
    assign accept   = s_tvalid && s_tready;
    assign last_go  = (state_reg == ST_RUN) && (step_reg == nr_reg)
                      && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        nr_next    = nr_reg;
        dec_next   = dec_reg;
        cmd.op     = aes_cbc_pkg::OP_NONE;
        cmd.dec    = dec_reg;
        cmd.rk_idx = dec_reg ? 4'd0 : nr_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.dec    = mode_reg;
                cmd.rk_idx = mode_reg ? kstat.nr : 4'd0;
                if (accept)
                begin
                    cmd.op     = aes_cbc_pkg::OP_LOAD;
                    state_next = ST_RUN;
                    step_next  = 4'd1;
                    nr_next    = kstat.nr;
                    dec_next   = mode_reg;
                end
            end
            ST_RUN:
            begin
                if (step_reg != nr_reg)
                begin
                    cmd.op     = aes_cbc_pkg::OP_ROUND;
                    cmd.rk_idx = dec_reg ? nr_reg - step_reg : step_reg;
                    step_next  = step_reg + 4'd1;
                end
                else if (last_go)
                begin
                    cmd.op     = aes_cbc_pkg::OP_LAST;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            nr_reg        <= 4'd10;
            dec_reg       <= 1'b0;
            mode_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            nr_reg        <= nr_next;
            dec_reg       <= dec_next;
            out_valid_reg <= last_go || (out_valid_reg && !m_tready);
            if (cfg_we && aes_cbc_pkg::cfg_idx_t'(cfg_index) == aes_cbc_pkg::CFG_DECRYPT_MODE)
                mode_reg <= cfg_data[0];
        end
    end

endmodule

>>> sv/aes_cbc_dp.sv
// Datapath: chaining store, shared round unit and output register.
module aes_cbc_dp #(
    parameter int STREAMS = aes_cbc_pkg::STREAMS_DEF
)
(
    input  logic                 clk,
    input  aes_cbc_pkg::dp_cmd_t cmd,
    input  logic [1:0]           stream,
    input  logic                 first_block,
    input  logic [127:0]         iv,
    input  logic [127:0]         data,
    input  logic [127:0]         rk,
    output logic [1:0]           out_stream,
    output logic [127:0]         out_data
);

    localparam int SW = (STREAMS > 1) ? $clog2(STREAMS) : 1;

    logic [127:0] chain_reg [STREAMS];
    logic [127:0] state_reg;
    logic [127:0] prev_reg;
    logic [1:0]   stream_reg;
    logic [SW-1:0] slot_reg;
    logic [1:0]   out_stream_reg;
    logic [127:0] out_data_reg;

    logic [4:0]    stream_w;
    logic [SW-1:0] slot;
    logic [127:0]  chain_in;
    logic [127:0]  enc_round;
    logic [127:0]  dec_round;
    logic [127:0]  enc_last;
    logic [127:0]  dec_last;

    // stream is below 4, so one compare and subtract wraps it for two or more slots
    assign stream_w = {3'b000, stream};
    assign slot     = (STREAMS == 1) ? '0 :
                      (stream_w >= 5'(STREAMS)) ? SW'(stream_w - 5'(STREAMS)) :
                      SW'(stream_w);
    assign chain_in = first_block ? iv : chain_reg[slot];

    assign enc_round = aes_cbc_pkg::mix_cols(aes_cbc_pkg::sub_shift(state_reg)) ^ rk;
    assign dec_round = aes_cbc_pkg::inv_mix_cols(aes_cbc_pkg::inv_sub_shift(state_reg) ^ rk);
    assign enc_last  = aes_cbc_pkg::sub_shift(state_reg) ^ rk;
    assign dec_last  = aes_cbc_pkg::inv_sub_shift(state_reg) ^ rk ^ prev_reg;

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            aes_cbc_pkg::OP_LOAD:
            begin
                stream_reg <= stream;
                slot_reg   <= slot;
                prev_reg   <= chain_in;
                if (cmd.dec)
                begin
                    state_reg       <= data ^ rk;
                    chain_reg[slot] <= data;
                end
                else
                begin
                    state_reg <= data ^ chain_in ^ rk;
                end
            end
            aes_cbc_pkg::OP_ROUND:
            begin
                state_reg <= cmd.dec ? dec_round : enc_round;
            end
            aes_cbc_pkg::OP_LAST:
            begin
                out_stream_reg <= stream_reg;
                if (cmd.dec)
                begin
                    out_data_reg <= dec_last;
                end
                else
                begin
                    out_data_reg        <= enc_last;
                    chain_reg[slot_reg] <= enc_last;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_stream = out_stream_reg;
    assign out_data   = out_data_reg;

endmodule

>>> sv/aes_cbc_cipher.sv
// AES-CBC cipher top level: stream ports, configuration port and unit wiring.
//
// Slave channel s_*: one word per 128-bit text block, tagged with its stream
// in s_tuser; the first block of a message sets s_tuser[2] and carries the IV.
// Master channel m_*: one word per input word, in input order, stream in m_tuser.
// Configuration: cfg_we/cfg_index/cfg_data write the key words, the key size
// and the mode; write only while no block is in flight.
// Flow: a block is taken and then goes through one shared round unit once
// per round; one block at a time.
// Key schedule: after reset and after every key or key size write the
// schedule is rebuilt one 32-bit word a cycle (44, 52 or 60 words), with
// s_tready low throughout. s_tready is also low in a cycle with cfg_we high.
// Reset: control cleared, key zero, AES-128 encryption; chaining values
// are undefined until a first block of their stream arrives.
// Stall: a finished word waits in the output register; the next word is
// accepted meanwhile, and its last round waits for that register to empty.
module aes_cbc_cipher #(
    parameter int STREAMS = aes_cbc_pkg::STREAMS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [255:0] s_tdata,   // iv_hi, iv_lo, data_hi, data_lo
    input  logic [2:0]   s_tuser,   // stream, first_block
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // out_hi, out_lo
    output logic [1:0]   m_tuser,   // out_stream
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    aes_cbc_pkg::key_stat_t kstat;
    aes_cbc_pkg::dp_cmd_t   cmd;
    logic [127:0]           rk;
    logic [127:0]           out_data;

    aes_cbc_kexp u_kexp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rk_idx    (cmd.rk_idx),
        .rk        (rk),
        .stat      (kstat)
    );

    aes_cbc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .kstat     (kstat),
        .cmd       (cmd)
    );

    aes_cbc_dp #(
        .STREAMS (STREAMS)
    ) u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .stream      (s_tuser[1:0]),
        .first_block (s_tuser[2]),
        .iv          ({s_tdata[63:0], s_tdata[127:64]}),
        .data        ({s_tdata[191:128], s_tdata[255:192]}),
        .rk          (rk),
        .out_stream  (m_tuser),
        .out_data    (out_data)
    );

    assign m_tdata = {out_data[63:0], out_data[127:64]};

endmodule

>>> sv/aes_cbc_chk.sv
// Port checker for the AES-CBC cipher, bound to the top level.
`include "aes_cbc_cipher_macros.svh"

module aes_cbc_chk
(
    input logic clk,
    input logic rst_n,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic cfg_we
);

    `ACC_ASSERT_NXT(a_out_held, m_tvalid && !m_tready, m_tvalid, "output word dropped while stalled")
    `ACC_ASSERT_IMP(a_cfg_blocks, cfg_we, !s_tready, "input taken during a configuration write")
    `ACC_ASSERT_NXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second word taken while busy")

endmodule

bind aes_cbc_cipher aes_cbc_chk u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_we   (cfg_we)
);
